// ===== sv/edfq_pkg.sv =====
`default_nettype none

package edfq_pkg;

  // Fixed field widths of the channels
  localparam int MODE_W   = 2;
  localparam int FID_W    = 8;
  localparam int FTIME_W  = 32;
  localparam int STAT_W   = 2;
  localparam int OCC_W    = 5;

  // Operation codes
  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CHECK  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;

  // Status codes
  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

  typedef logic [FID_W-1:0]   fid_t;
  typedef logic [FTIME_W-1:0] ftime_t;

endpackage

`default_nettype wire

// ===== sv/edfq_ifs.sv =====
`default_nettype none

interface edfq_in_if;
  import edfq_pkg::*;

  logic                valid;
  logic                ready;
  logic [MODE_W-1:0]   mode;
  fid_t                job_id;
  ftime_t              job_deadline;
  ftime_t              job_exec_time;
  ftime_t              check_time;

  modport source (output valid, mode, job_id, job_deadline, job_exec_time, check_time,
                  input ready);
  modport sink (input valid, mode, job_id, job_deadline, job_exec_time, check_time,
                output ready);
endinterface

interface edfq_out_if;
  import edfq_pkg::*;

  logic                valid;
  logic                ready;
  logic [STAT_W-1:0]   status;
  logic                miss_found;
  fid_t                miss_job_id;
  fid_t                removed_job_id;
  logic [OCC_W-1:0]    occupancy;

  modport source (output valid, status, miss_found, miss_job_id, removed_job_id, occupancy,
                  input ready);
  modport sink (input valid, status, miss_found, miss_job_id, removed_job_id, occupancy,
                output ready);
endinterface

`default_nettype wire

// ===== sv/edf_deadline_queue_core.sv =====
`default_nettype none

// Earliest-deadline-first job queue. Jobs (id, absolute deadline, remaining
// time) live in one synchronous memory used as a ring, logically sorted by
// deadline from the head; equal deadlines keep arrival order. Each input beat
// carries one operation and yields exactly one result beat. Insert into a
// non-empty queue walks from the tail toward the head, moving each job with a
// later deadline up by one slot, one entry per cycle. Check walks from the
// head, adding remaining times to check_time one entry per cycle, and stops
// at the first job that completes past its deadline. Remove reads the head
// entry and advances the ring head. Insert into an empty or a full queue,
// check on an empty queue, remove on an empty queue and the unused mode go
// straight from the accepting step to the finish step. The walks handle one
// entry at a time because the memory has a single read port with registered
// read data. A new beat is taken as soon as the previous operation has handed
// its result to the output register, even while that result still waits for
// out_ch.ready. No memory clearing is needed after reset.
module edf_deadline_queue_core #(
  parameter int DEPTH     = 16,
  parameter int TIME_BITS = 32,
  parameter int ID_BITS   = 8
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  edfq_in_if.sink     in_ch,
  edfq_out_if.source  out_ch
);
  import edfq_pkg::*;

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int ENT_W = ID_BITS + 2 * TIME_BITS;
  localparam logic [IDX_W:0]   DEPTH_W   = (IDX_W + 1)'(DEPTH);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

  // Sequencer states
  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_INS      = 3'd1;
  localparam logic [2:0] S_INS_LAST = 3'd2;
  localparam logic [2:0] S_CHK      = 3'd3;
  localparam logic [2:0] S_REM      = 3'd4;
  localparam logic [2:0] S_DONE     = 3'd5;

  // Map a logical queue position onto its ring slot
  function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] head,
                                            input logic [IDX_W-1:0] pos);
    logic [IDX_W:0] s;
    s = {1'b0, head} + {1'b0, pos};
    if (s >= DEPTH_W) begin
      s = s - DEPTH_W;
    end
    return s[IDX_W-1:0];
  endfunction

  // Control state
  logic [2:0]       state_r, state_nxt;
  logic [IDX_W-1:0] head_r, head_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             out_valid_r, out_valid_nxt;

  // Operation payload
  logic [IDX_W-1:0]     k_r, k_nxt;
  logic [ID_BITS-1:0]   id_r, id_nxt;
  logic [TIME_BITS-1:0] dl_r, dl_nxt;
  logic [TIME_BITS-1:0] ex_r, ex_nxt;
  logic [TIME_BITS-1:0] t_r, t_nxt;
  logic [STAT_W-1:0]    res_status_r, res_status_nxt;
  logic                 res_miss_r, res_miss_nxt;
  fid_t                 res_miss_id_r, res_miss_id_nxt;
  fid_t                 res_removed_r, res_removed_nxt;
  logic [STAT_W-1:0]    out_status_r, out_status_nxt;
  logic                 out_miss_r, out_miss_nxt;
  fid_t                 out_miss_id_r, out_miss_id_nxt;
  fid_t                 out_removed_r, out_removed_nxt;
  logic [OCC_W-1:0]     out_occ_r, out_occ_nxt;

  // Job memory: {id, deadline, remaining}
  logic [ENT_W-1:0] mem [DEPTH];
  logic [ENT_W-1:0] mem_rd_r;
  logic [IDX_W-1:0] mem_ra, mem_wa;
  logic [ENT_W-1:0] mem_wd;
  logic             mem_we;

  logic [ID_BITS-1:0]   ent_id;
  logic [TIME_BITS-1:0] ent_dl, ent_rem;
  logic [TIME_BITS:0]   sum;
  logic [IDX_W-1:0]     k_inc, k_dec, tail_pos;
  logic                 accept;

  assign ent_id   = mem_rd_r[ENT_W-1 -: ID_BITS];
  assign ent_dl   = mem_rd_r[2*TIME_BITS-1 -: TIME_BITS];
  assign ent_rem  = mem_rd_r[TIME_BITS-1:0];
  assign sum      = {1'b0, t_r} + {1'b0, ent_rem};
  assign k_inc    = k_r + IDX_W'(1);
  assign k_dec    = k_r - IDX_W'(1);
  assign tail_pos = IDX_W'(count_r - CNT_W'(1));

  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;

  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = out_status_r;
  assign out_ch.miss_found     = out_miss_r;
  assign out_ch.miss_job_id    = out_miss_id_r;
  assign out_ch.removed_job_id = out_removed_r;
  assign out_ch.occupancy      = out_occ_r;

  always_comb begin
    state_nxt       = state_r;
    head_nxt        = head_r;
    count_nxt       = count_r;
    out_valid_nxt   = out_valid_r;
    k_nxt           = k_r;
    id_nxt          = id_r;
    dl_nxt          = dl_r;
    ex_nxt          = ex_r;
    t_nxt           = t_r;
    res_status_nxt  = res_status_r;
    res_miss_nxt    = res_miss_r;
    res_miss_id_nxt = res_miss_id_r;
    res_removed_nxt = res_removed_r;
    out_status_nxt  = out_status_r;
    out_miss_nxt    = out_miss_r;
    out_miss_id_nxt = out_miss_id_r;
    out_removed_nxt = out_removed_r;
    out_occ_nxt     = out_occ_r;
    mem_ra          = phys(head_r, k_r);
    mem_wa          = phys(head_r, k_inc);
    mem_wd          = mem_rd_r;
    mem_we          = 1'b0;

    // Drop the result beat once taken
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          id_nxt          = ID_BITS'(in_ch.job_id);
          dl_nxt          = TIME_BITS'(in_ch.job_deadline);
          ex_nxt          = TIME_BITS'(in_ch.job_exec_time);
          t_nxt           = TIME_BITS'(in_ch.check_time);
          res_status_nxt  = STAT_OK;
          res_miss_nxt    = 1'b0;
          res_miss_id_nxt = '0;
          res_removed_nxt = '0;
          state_nxt       = S_DONE;
          case (in_ch.mode)
            MODE_INSERT: begin
              if (count_r == DEPTH_CNT) begin
                res_status_nxt = STAT_FULL;
              end else if (count_r == '0) begin
                // Empty ring: place the job at the head directly
                mem_we    = 1'b1;
                mem_wa    = head_r;
                mem_wd    = {ID_BITS'(in_ch.job_id), TIME_BITS'(in_ch.job_deadline),
                             TIME_BITS'(in_ch.job_exec_time)};
                count_nxt = count_r + CNT_W'(1);
              end else begin
                k_nxt     = tail_pos;
                mem_ra    = phys(head_r, tail_pos);
                state_nxt = S_INS;
              end
            end
            MODE_CHECK: begin
              if (count_r != '0) begin
                k_nxt     = '0;
                mem_ra    = head_r;
                state_nxt = S_CHK;
              end
            end
            MODE_REMOVE: begin
              if (count_r == '0) begin
                res_status_nxt = STAT_EMPTY;
              end else begin
                mem_ra    = head_r;
                state_nxt = S_REM;
              end
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      S_INS: begin
        // Entry k is in mem_rd_r; slot k+1 is free
        mem_we = 1'b1;
        mem_wa = phys(head_r, k_inc);
        if (ent_dl > dl_r) begin
          mem_wd = mem_rd_r;
          if (k_r == '0) begin
            state_nxt = S_INS_LAST;
          end else begin
            k_nxt  = k_dec;
            mem_ra = phys(head_r, k_dec);
          end
        end else begin
          mem_wd    = {id_r, dl_r, ex_r};
          count_nxt = count_r + CNT_W'(1);
          state_nxt = S_DONE;
        end
      end

      S_INS_LAST: begin
        mem_we    = 1'b1;
        mem_wa    = head_r;
        mem_wd    = {id_r, dl_r, ex_r};
        count_nxt = count_r + CNT_W'(1);
        state_nxt = S_DONE;
      end

      S_CHK: begin
        if (sum > {1'b0, ent_dl}) begin
          res_miss_nxt    = 1'b1;
          res_miss_id_nxt = FID_W'(ent_id);
          state_nxt       = S_DONE;
        end else begin
          t_nxt = sum[TIME_BITS-1:0];
          if ((CNT_W'(k_r) + CNT_W'(1)) == count_r) begin
            state_nxt = S_DONE;
          end else begin
            k_nxt  = k_inc;
            mem_ra = phys(head_r, k_inc);
          end
        end
      end

      S_REM: begin
        res_removed_nxt = FID_W'(ent_id);
        head_nxt        = phys(head_r, IDX_W'(1));
        count_nxt       = count_r - CNT_W'(1);
        state_nxt       = S_DONE;
      end

      S_DONE: begin
        // Hold until the output register is free
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt   = 1'b1;
          out_status_nxt  = res_status_r;
          out_miss_nxt    = res_miss_r;
          out_miss_id_nxt = res_miss_id_r;
          out_removed_nxt = res_removed_r;
          out_occ_nxt     = OCC_W'(count_r);
          state_nxt       = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r           <= k_nxt;
    id_r          <= id_nxt;
    dl_r          <= dl_nxt;
    ex_r          <= ex_nxt;
    t_r           <= t_nxt;
    res_status_r  <= res_status_nxt;
    res_miss_r    <= res_miss_nxt;
    res_miss_id_r <= res_miss_id_nxt;
    res_removed_r <= res_removed_nxt;
    out_status_r  <= out_status_nxt;
    out_miss_r    <= out_miss_nxt;
    out_miss_id_r <= out_miss_id_nxt;
    out_removed_r <= out_removed_nxt;
    out_occ_r     <= out_occ_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    mem_rd_r <= mem[mem_ra];
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_CNT)
    else $error("job count beyond depth");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != $past(count_r)) |->
      (count_r == $past(count_r) + CNT_W'(1) || count_r == $past(count_r) - CNT_W'(1)))
    else $error("job count moved by more than one");

  a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_INS || state_r == S_CHK) |-> (CNT_W'(k_r) < count_r))
    else $error("walk index outside the held jobs");

  a_ins_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_INS || state_r == S_INS_LAST) |-> (count_r < DEPTH_CNT))
    else $error("insert walk on a full queue");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_DONE))
    else $error("result beat raised outside the finish step");
`endif

endmodule

`default_nettype wire

// ===== tb/edf_deadline_queue_core_tb.sv =====
`timescale 1ns / 1ps

module edf_deadline_queue_core_tb;
  import edfq_pkg::*;

  // Queue size under test; keep in step with the occupancy field width.
  localparam int QUEUE_DEPTH = 16;

  // The mode field has one code with no operation behind it.
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  // Bound on the closing wait, in cycles, and the quiet tail after it.
  localparam int DRAIN_LIMIT = 10000;
  localparam int TAIL_CYCLES = 40;
  localparam int REPORT_MAX  = 10;

  // One result beat, field for field.
  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic              miss_found;
    fid_t              miss_job_id;
    fid_t              removed_job_id;
    logic [OCC_W-1:0]  occupancy;
  } edf_result_t;

  logic clk = 1'b0;
  logic rst_n;

  edfq_in_if  in_ch();
  edfq_out_if out_ch();

  edf_deadline_queue_core #(
    .DEPTH    (QUEUE_DEPTH),
    .TIME_BITS(FTIME_W),
    .ID_BITS  (FID_W)
  ) DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // 8 ns period: high half, then low half.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Shadow copy of the job queue, sorted by deadline from index 0.
  fid_t   shadow_ids       [QUEUE_DEPTH];
  ftime_t shadow_deadlines [QUEUE_DEPTH];
  ftime_t shadow_remaining [QUEUE_DEPTH];
  int     shadow_count;

  // Results owed by the block, oldest first.
  edf_result_t due_results[$];

  int send_idle_pct;
  int recv_idle_pct;
  int mismatch_count;
  int results_seen;

  // Coverage tallies for the closing summary.
  int n_insert, n_full, n_check, n_miss, n_remove, n_empty, n_unused;

  // Apply one operation to the shadow queue and return the result it owes.
  function automatic edf_result_t edf_apply_op(logic [MODE_W-1:0] op, fid_t id,
                                               ftime_t dl, ftime_t ex, ftime_t now);
    edf_result_t      res;
    logic [FTIME_W:0] finish_at;
    int               pos;
    int               k;
    res = '0;
    case (op)
      MODE_INSERT: begin
        n_insert++;
        if (shadow_count >= QUEUE_DEPTH) begin
          res.status = STAT_FULL;
          n_full++;
        end else begin
          // Go past every job due at or before the new one: ties keep arrival order.
          pos = 0;
          while (pos < shadow_count && shadow_deadlines[pos] <= dl)
            pos++;
          for (k = shadow_count; k > pos; k--) begin
            shadow_ids[k]       = shadow_ids[k-1];
            shadow_deadlines[k] = shadow_deadlines[k-1];
            shadow_remaining[k] = shadow_remaining[k-1];
          end
          shadow_ids[pos]       = id;
          shadow_deadlines[pos] = dl;
          shadow_remaining[pos] = ex;
          shadow_count++;
        end
      end
      MODE_CHECK: begin
        n_check++;
        // One extra bit holds the sum: it stays at or under a deadline before each add.
        finish_at = {1'b0, now};
        for (k = 0; k < shadow_count; k++) begin
          finish_at = finish_at + shadow_remaining[k];
          if (finish_at > {1'b0, shadow_deadlines[k]}) begin
            res.miss_found  = 1'b1;
            res.miss_job_id = shadow_ids[k];
            n_miss++;
            break;
          end
        end
      end
      MODE_REMOVE: begin
        n_remove++;
        if (shadow_count == 0) begin
          res.status = STAT_EMPTY;
          n_empty++;
        end else begin
          res.removed_job_id = shadow_ids[0];
          for (k = 1; k < shadow_count; k++) begin
            shadow_ids[k-1]       = shadow_ids[k];
            shadow_deadlines[k-1] = shadow_deadlines[k];
            shadow_remaining[k-1] = shadow_remaining[k];
          end
          shadow_count--;
        end
      end
      default: n_unused++;
    endcase
    res.occupancy = shadow_count[OCC_W-1:0];
    return res;
  endfunction

  function automatic string result_text(edf_result_t r);
    return $sformatf("status=%0d miss=%0d miss_id=0x%02h removed=0x%02h occ=%0d",
                     r.status, r.miss_found, r.miss_job_id, r.removed_job_id,
                     r.occupancy);
  endfunction

  task automatic flag_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= REPORT_MAX)
      $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // Drive one beat at the falling edge, after a random number of idle cycles,
  // and hold it until the block takes it at a rising edge.
  task automatic send_job(logic [MODE_W-1:0] op, fid_t id, ftime_t dl, ftime_t ex,
                          ftime_t now);
    edf_result_t owed;
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.mode          <= op;
    in_ch.job_id        <= id;
    in_ch.job_deadline  <= dl;
    in_ch.job_exec_time <= ex;
    in_ch.check_time    <= now;
    do @(posedge clk); while (!in_ch.ready);
    owed = edf_apply_op(op, id, dl, ex, now);
    due_results.insert(due_results.size(), owed);
  endtask

  // Drop valid and hold off until every owed result has come back.
  task automatic wait_results_drained();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (due_results.size() != 0)
      @(posedge clk);
  endtask

  // Receiver stalls: decide ready at each falling edge.
  always @(negedge clk) begin
    if (rst_n)
      out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Score each result beat against the oldest owed result.
  always @(posedge clk) begin : result_check
    edf_result_t want;
    edf_result_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      got.status         = out_ch.status;
      got.miss_found     = out_ch.miss_found;
      got.miss_job_id    = out_ch.miss_job_id;
      got.removed_job_id = out_ch.removed_job_id;
      got.occupancy      = out_ch.occupancy;
      if (due_results.size() == 0) begin
        flag_mismatch({"result beat with nothing owed: ", result_text(got)});
      end else begin
        want = due_results[0];
        due_results.delete(0);
        if (got.status !== want.status || got.miss_found !== want.miss_found ||
            got.miss_job_id !== want.miss_job_id ||
            got.removed_job_id !== want.removed_job_id ||
            got.occupancy !== want.occupancy)
          flag_mismatch({"want ", result_text(want), " | got ", result_text(got)});
      end
    end
  end

  // Remove, check and the unused code on an empty queue.
  task automatic test_empty_queue();
    send_job(MODE_REMOVE, 8'h5A, '0, '0, '0);
    send_job(MODE_CHECK, 8'hA5, '0, '0, ~ftime_t'(0));
    send_job(MODE_UNUSED, 8'hFF, ~ftime_t'(0), ~ftime_t'(0), ~ftime_t'(0));
  endtask

  // Fill to capacity with extreme and tied deadlines, then overflow once.
  task automatic test_fill_to_full();
    int k;
    send_job(MODE_INSERT, 8'h00, '0, '0, '0);
    send_job(MODE_INSERT, 8'hFF, ~ftime_t'(0), ~ftime_t'(0), '0);
    send_job(MODE_INSERT, 8'h11, 32'd100, 32'd10, '0);
    send_job(MODE_INSERT, 8'h12, 32'd100, 32'd20, '0);
    send_job(MODE_INSERT, 8'h13, 32'd50, 32'd5, '0);
    send_job(MODE_INSERT, 8'h14, 32'd100, 32'd30, '0);
    for (k = 6; k < QUEUE_DEPTH; k++)
      send_job(MODE_INSERT, fid_t'(8'h20 + k), ftime_t'(200 + 13 * k), ftime_t'(k), '0);
    send_job(MODE_INSERT, 8'hEE, 32'd1, 32'd1, '0);
  endtask

  // Walks on a full queue: miss at the tail through the wide sum, miss at the
  // head, then the unused code and one dispatch.
  task automatic test_feasibility_walk();
    send_job(MODE_CHECK, 8'h00, '0, '0, '0);
    send_job(MODE_CHECK, 8'h00, '0, '0, 32'd1);
    send_job(MODE_CHECK, 8'h00, '0, '0, ~ftime_t'(0));
    send_job(MODE_UNUSED, 8'h77, 32'h1234_5678, 32'h8765_4321, 32'h0F0F_0F0F);
    send_job(MODE_REMOVE, 8'h00, '0, '0, '0);
  endtask

  // Mixed traffic around a time base; occupancy steers the insert/remove mix
  // so the queue swings between empty and full.
  task automatic test_random_mix(int beats, int s_pct, int r_pct, ftime_t base);
    logic [MODE_W-1:0] op;
    ftime_t            dl, ex, now;
    int                roll, grow_pct, n;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    for (n = 0; n < beats; n++) begin
      roll     = $urandom_range(0, 99);
      grow_pct = (shadow_count < 4) ? 80 : (shadow_count > 12) ? 35 : 55;
      if (roll < 3)
        op = MODE_UNUSED;
      else if (roll < 35)
        op = MODE_CHECK;
      else if ($urandom_range(0, 99) < grow_pct)
        op = MODE_INSERT;
      else
        op = MODE_REMOVE;

      roll = $urandom_range(0, 9);
      if (roll == 0) begin
        dl = $urandom;
        ex = $urandom;
      end else if (roll == 1) begin
        dl = ($urandom_range(0, 1) == 0) ? ftime_t'(0) : ~ftime_t'(0);
        ex = ($urandom_range(0, 1) == 0) ? ~ftime_t'(0) : ftime_t'($urandom_range(0, 3));
      end else if (roll == 2 && shadow_count != 0) begin
        // Reuse a held deadline to force a tie.
        dl = shadow_deadlines[$urandom_range(0, shadow_count - 1)];
        ex = $urandom_range(0, 60);
      end else begin
        dl = base + $urandom_range(0, 400);
        ex = $urandom_range(0, 60);
      end
      now = ($urandom_range(0, 7) == 0) ? ftime_t'($urandom) : base + $urandom_range(0, 200);

      send_job(op, fid_t'($urandom), dl, ex, now);
      if ($urandom_range(0, 39) == 0)
        wait_results_drained();
    end
  endtask

  initial begin
    int k;
    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.mode          = MODE_INSERT;
    in_ch.job_id        = '0;
    in_ch.job_deadline  = '0;
    in_ch.job_exec_time = '0;
    in_ch.check_time    = '0;
    out_ch.ready        = 1'b0;
    shadow_count        = 0;
    mismatch_count      = 0;
    results_seen        = 0;
    send_idle_pct       = 23;
    recv_idle_pct       = 65;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_queue();
    test_fill_to_full();
    test_feasibility_walk();

    // Sender sparse, receiver busy; then the reverse; then full rate.
    test_random_mix(150, 23, 65, 32'h0000_1000);
    wait_results_drained();
    test_random_mix(150, 65, 23, 32'h8000_0000);
    wait_results_drained();
    test_random_mix(150, 0, 0, 32'hFFFF_FF00);

    // Close out: drop valid, collect what is owed, then let the block settle.
    @(negedge clk);
    in_ch.valid <= 1'b0;
    for (k = 0; k < DRAIN_LIMIT && due_results.size() != 0; k++)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (due_results.size() != 0)
      flag_mismatch($sformatf("%0d results never arrived", due_results.size()));

    $display("Covered %0d result beats: %0d inserts (%0d on full), %0d checks (%0d misses),",
             results_seen, n_insert, n_full, n_check, n_miss);
    $display("  %0d removes (%0d on empty), %0d unused-mode beats; %0d mismatches.",
             n_remove, n_empty, n_unused, mismatch_count);
    if (mismatch_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Hard stop well past the slowest legal run.
  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
